/* rtl/iac_pkg.sv */
// Shared types and constants of the intrusion alarm controller.
package iac_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISARM_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREALERT_ON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREALERT_OFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ON      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_OFF     = 3'd5;

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ARMED    = 2'd1,
    MODE_WINDOW   = 2'd2,
    MODE_ALARMING = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_MOVEMENT = 3'd1,
    EV_HALL     = 3'd2,
    EV_DUAL     = 3'd3,
    EV_DISARMED = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [9:0]  settle_ms;
    logic [23:0] grace_ms;
    logic [15:0] prealert_on_ms;
    logic [15:0] prealert_off_ms;
    logic [15:0] alarm_on_ms;
    logic [15:0] alarm_off_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] epoch_time;
    logic        button_level;
    logic        motion_fresh;
    logic        hall_fresh;
    logic [31:0] motion_count;
    logic [31:0] hall_count;
  } tick_t;

  typedef struct packed {
    mode_t       mode;
    logic        raw_button_prev;
    logic        button_stable;
    logic [31:0] button_edge_time;
    logic        buzzer_level;
    logic        led_level;
    logic [31:0] phase_start_time;
    logic [31:0] window_start_time;
    logic [31:0] seen_motion_count;
    logic [31:0] seen_hall_count;
  } state_t;

  // Results of one tick: up to three events sharing one status.
  typedef struct packed {
    logic [1:0]             n_res;
    event_kind_t [2:0]      kinds;
    logic [31:0]            epoch;
    mode_t                  mode;
    logic                   buzzer_on;
    logic                   led_on;
    logic                   alert_request;
  } record_t;

endpackage

/* rtl/iac_tick_if.sv */
// Input tick channel.
interface iac_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [31:0] epoch_time;
  logic        button_level;
  logic        motion_fresh;
  logic        hall_fresh;
  logic [31:0] motion_count;
  logic [31:0] hall_count;

  modport source (
    output valid, now_ms, epoch_time, button_level, motion_fresh, hall_fresh,
           motion_count, hall_count,
    input  ready
  );
  modport sink (
    input  valid, now_ms, epoch_time, button_level, motion_fresh, hall_fresh,
           motion_count, hall_count,
    output ready
  );
endinterface

/* rtl/iac_result_if.sv */
// Result channel.
interface iac_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [31:0] event_time;
  logic [1:0]  alarm_mode;
  logic        buzzer_on;
  logic        led_on;
  logic        alert_request;
  logic        last_of_tick;

  modport source (
    output valid, event_kind, event_time, alarm_mode, buzzer_on, led_on,
           alert_request, last_of_tick,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_time, alarm_mode, buzzer_on, led_on,
           alert_request, last_of_tick,
    output ready
  );
endinterface

/* rtl/iac_cfg_if.sv */
// Configuration write channel.
interface iac_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [iac_pkg::CFG_IDX_W-1:0]   index;
  logic [iac_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/iac_step.sv */
// Next-state and event logic for one tick.
module iac_step (
  input  iac_pkg::state_t  state,
  input  iac_pkg::cfg_t    cfg,
  input  iac_pkg::tick_t   tick,
  output iac_pkg::state_t  state_next,
  output iac_pkg::record_t rec_next
);

  logic        pressed;
  logic        ev_motion;
  logic        ev_hall;
  logic        ev_last;
  logic        alert;
  logic        pat_hit;
  logic [31:0] pat_len;
  logic [31:0] since_edge;
  logic [31:0] since_phase;
  logic [31:0] since_window;
  logic [1:0]  cnt;
  iac_pkg::event_kind_t last_kind;
  iac_pkg::event_kind_t [2:0] kinds;

  always_comb begin
    state_next = state;
    pressed    = 1'b0;
    ev_last    = 1'b0;
    last_kind  = iac_pkg::EV_NONE;
    alert      = 1'b0;
    pat_len    = '0;

    // debounce
    if (tick.button_level != state.raw_button_prev) begin
      state_next.button_edge_time = tick.now_ms;
      state_next.raw_button_prev  = tick.button_level;
    end
    since_edge = tick.now_ms - state_next.button_edge_time;
    if (since_edge >= {22'd0, cfg.settle_ms} && tick.button_level != state.button_stable) begin
      state_next.button_stable = tick.button_level;
      pressed = !tick.button_level;
    end

    // trigger counts, judged on the mode at the start of the tick
    ev_motion = (state.mode != iac_pkg::MODE_DISARMED) &&
                (tick.motion_count != state.seen_motion_count);
    ev_hall   = (state.mode != iac_pkg::MODE_DISARMED) &&
                (tick.hall_count != state.seen_hall_count);
    if (ev_motion) state_next.seen_motion_count = tick.motion_count;
    if (ev_hall)   state_next.seen_hall_count   = tick.hall_count;

    // buzzer pattern timing
    case (state.mode)
      iac_pkg::MODE_WINDOW:
        pat_len = state.buzzer_level ? {16'd0, cfg.prealert_on_ms} :
                                       {16'd0, cfg.prealert_off_ms};
      iac_pkg::MODE_ALARMING:
        pat_len = state.buzzer_level ? {16'd0, cfg.alarm_on_ms} :
                                       {16'd0, cfg.alarm_off_ms};
      default: pat_len = '0;
    endcase
    since_phase  = tick.now_ms - state.phase_start_time;
    since_window = tick.now_ms - state.window_start_time;
    pat_hit      = since_phase >= pat_len;

    case (state.mode)
      iac_pkg::MODE_DISARMED: begin
        state_next.buzzer_level = 1'b0;
        if (pressed) state_next.mode = iac_pkg::MODE_ARMED;
      end
      iac_pkg::MODE_ARMED: begin
        state_next.buzzer_level = 1'b0;
        if (pressed) begin
          state_next.mode = iac_pkg::MODE_DISARMED;
        end else if (tick.motion_fresh && tick.hall_fresh) begin
          state_next.mode              = iac_pkg::MODE_WINDOW;
          state_next.window_start_time = tick.now_ms;
          state_next.phase_start_time  = tick.now_ms;
          state_next.buzzer_level      = 1'b1;
          state_next.led_level         = 1'b1;
          ev_last   = 1'b1;
          last_kind = iac_pkg::EV_DUAL;
        end
      end
      iac_pkg::MODE_WINDOW: begin
        if (pat_hit) begin
          state_next.phase_start_time = tick.now_ms;
          state_next.buzzer_level     = !state.buzzer_level;
          state_next.led_level        = !state.buzzer_level;
        end
        if (pressed) begin
          state_next.buzzer_level = 1'b0;
          state_next.mode         = iac_pkg::MODE_ARMED;
          ev_last   = 1'b1;
          last_kind = iac_pkg::EV_DISARMED;
        end else if (since_window >= {8'd0, cfg.grace_ms}) begin
          state_next.mode             = iac_pkg::MODE_ALARMING;
          state_next.phase_start_time = tick.now_ms;
          state_next.buzzer_level     = 1'b1;
          state_next.led_level        = 1'b1;
          alert = 1'b1;
        end
      end
      default: begin
        if (pat_hit) begin
          state_next.phase_start_time = tick.now_ms;
          state_next.buzzer_level     = !state.buzzer_level;
          state_next.led_level        = !state.buzzer_level;
        end
        if (pressed) begin
          state_next.buzzer_level = 1'b0;
          state_next.mode         = iac_pkg::MODE_ARMED;
          ev_last   = 1'b1;
          last_kind = iac_pkg::EV_DISARMED;
        end
      end
    endcase

    // pack events in order
    kinds[0] = iac_pkg::EV_NONE;
    kinds[1] = iac_pkg::EV_NONE;
    kinds[2] = iac_pkg::EV_NONE;
    cnt   = 2'd0;
    if (ev_motion) begin
      kinds[cnt] = iac_pkg::EV_MOVEMENT;
      cnt = cnt + 2'd1;
    end
    if (ev_hall) begin
      kinds[cnt] = iac_pkg::EV_HALL;
      cnt = cnt + 2'd1;
    end
    if (ev_last) begin
      kinds[cnt] = last_kind;
      cnt = cnt + 2'd1;
    end

    rec_next.kinds         = kinds;
    rec_next.n_res         = (cnt == 2'd0) ? 2'd1 : cnt;
    rec_next.epoch         = (cnt == 2'd0) ? 32'd0 : tick.epoch_time;
    rec_next.mode          = state_next.mode;
    rec_next.buzzer_on     = state_next.buzzer_level;
    rec_next.led_on        = state_next.led_level;
    rec_next.alert_request = alert;
  end

endmodule

/* rtl/intrusion_alarm_controller.sv */
// Intrusion alarm controller top level.
// Ticks enter an input register, one per cycle while tick.ready is high.
// When a tick leaves that register the debounce, mode and buzzer logic
// runs combinationally and its one to three results land in a result
// register, presented one per cycle while result.ready is high, the last
// carrying last_of_tick; a tick with no events still yields one result.
// A tick passes the input register, then the result register. The input
// register takes a new tick while earlier results are still waiting.
// Configuration writes are always ready and take effect on the next tick.
module intrusion_alarm_controller (
  input  logic               clk,
  input  logic               rst,
  iac_tick_if.sink           tick,
  iac_result_if.source       result,
  iac_cfg_if.sink            cfg
);

  iac_pkg::cfg_t    cfg_regs;
  iac_pkg::tick_t   s1;
  logic             s1_valid;
  iac_pkg::state_t  state;
  iac_pkg::state_t  state_next;
  iac_pkg::record_t rec;
  iac_pkg::record_t rec_next;
  logic             rec_valid;
  logic [1:0]       idx;
  logic             last;
  logic             out_take;
  logic             rec_done;
  logic             s1_move;

  iac_step u_step (
    .state      (state),
    .cfg        (cfg_regs),
    .tick       (s1),
    .state_next (state_next),
    .rec_next   (rec_next)
  );

  assign last     = idx == (rec.n_res - 2'd1);
  assign out_take = rec_valid && result.ready;
  assign rec_done = out_take && last;
  assign s1_move  = s1_valid && (!rec_valid || rec_done);

  assign tick.ready  = !s1_valid || s1_move;
  assign cfg.ready   = 1'b1;

  assign result.valid         = rec_valid;
  assign result.event_kind    = rec.kinds[idx];
  assign result.event_time    = rec.epoch;
  assign result.alarm_mode    = rec.mode;
  assign result.buzzer_on     = rec.buzzer_on;
  assign result.led_on        = rec.led_on;
  assign result.alert_request = rec.alert_request;
  assign result.last_of_tick  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.settle_ms       <= 10'd50;
      cfg_regs.grace_ms        <= 24'd30000;
      cfg_regs.prealert_on_ms  <= 16'd200;
      cfg_regs.prealert_off_ms <= 16'd800;
      cfg_regs.alarm_on_ms     <= 16'd500;
      cfg_regs.alarm_off_ms    <= 16'd500;
    end else if (cfg.valid) begin
      case (cfg.index)
        iac_pkg::CFG_DEBOUNCE:      cfg_regs.settle_ms       <= cfg.data[9:0];
        iac_pkg::CFG_DISARM_WINDOW: cfg_regs.grace_ms        <= cfg.data;
        iac_pkg::CFG_PREALERT_ON:   cfg_regs.prealert_on_ms  <= cfg.data[15:0];
        iac_pkg::CFG_PREALERT_OFF:  cfg_regs.prealert_off_ms <= cfg.data[15:0];
        iac_pkg::CFG_ALARM_ON:      cfg_regs.alarm_on_ms     <= cfg.data[15:0];
        iac_pkg::CFG_ALARM_OFF:     cfg_regs.alarm_off_ms    <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (tick.valid && tick.ready) begin
      s1.now_ms       <= tick.now_ms;
      s1.epoch_time   <= tick.epoch_time;
      s1.button_level <= tick.button_level;
      s1.motion_fresh <= tick.motion_fresh;
      s1.hall_fresh   <= tick.hall_fresh;
      s1.motion_count <= tick.motion_count;
      s1.hall_count   <= tick.hall_count;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode              <= iac_pkg::MODE_DISARMED;
      state.raw_button_prev   <= 1'b1;
      state.button_stable     <= 1'b1;
      state.button_edge_time  <= '0;
      state.buzzer_level      <= 1'b0;
      state.led_level         <= 1'b0;
      state.phase_start_time  <= '0;
      state.window_start_time <= '0;
      state.seen_motion_count <= '0;
      state.seen_hall_count   <= '0;
    end else if (s1_move) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (s1_move) begin
      rec_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (rec_done) begin
      rec_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (out_take) begin
      idx <= idx + 2'd1;
    end
    if (s1_move) begin
      rec <= rec_next;
    end
  end

endmodule
